FILE: rtl/core/smeu_pkg.sv
// shared types and constants of the stack machine execute unit
`default_nettype none
package smeu_pkg;

  typedef struct packed {
    logic [7:0]         action;
    logic               wide;
    logic [7:0]         operand_a;
    logic [7:0]         operand_b;
    logic signed [31:0] pool_word;
    logic [15:0]        method_args;
    logic [15:0]        method_locals;
    logic [7:0]         in_char;
    logic               in_valid;
  } req_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               out_valid;
    logic [7:0]         out_char;
    logic [2:0]         status;
    logic signed [31:0] top_word;
  } rsp_t;

  localparam logic [7:0] OP_NOP         = 8'h00;
  localparam logic [7:0] OP_PUSH_BYTE   = 8'h10;
  localparam logic [7:0] OP_PUSH_CONST  = 8'h13;
  localparam logic [7:0] OP_LOAD_LOCAL  = 8'h15;
  localparam logic [7:0] OP_STORE_LOCAL = 8'h36;
  localparam logic [7:0] OP_POP         = 8'h57;
  localparam logic [7:0] OP_DUP         = 8'h59;
  localparam logic [7:0] OP_SWAP        = 8'h5F;
  localparam logic [7:0] OP_IADD        = 8'h60;
  localparam logic [7:0] OP_ISUB        = 8'h64;
  localparam logic [7:0] OP_IAND        = 8'h7E;
  localparam logic [7:0] OP_IINC        = 8'h84;
  localparam logic [7:0] OP_IFEQ        = 8'h99;
  localparam logic [7:0] OP_IFLT        = 8'h9B;
  localparam logic [7:0] OP_IF_ICMPEQ   = 8'h9F;
  localparam logic [7:0] OP_GOTO        = 8'hA7;
  localparam logic [7:0] OP_RETURN      = 8'hAC;
  localparam logic [7:0] OP_IOR         = 8'hB0;
  localparam logic [7:0] OP_INVOKE      = 8'hB6;
  localparam logic [7:0] OP_WIDE        = 8'hC4;
  localparam logic [7:0] OP_IN          = 8'hFC;
  localparam logic [7:0] OP_OUT         = 8'hFD;
  localparam logic [7:0] OP_ERR         = 8'hFE;
  localparam logic [7:0] OP_HALT        = 8'hFF;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_BOUND = 3'd4;

  // wide enough for local base plus two 16-bit counts
  localparam int CALC_W = 18;

endpackage
`default_nettype wire

FILE: rtl/core/smeu_if.sv
// request and result channel interfaces
`default_nettype none
interface smeu_req_if;
  import smeu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smeu_rsp_if;
  import smeu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/stack_machine_execute_unit.sv
// stack machine execute unit: sequencer, stack, frame and local memories
//
// channel  dir  contents
// req      in   opcode, wide flag, operand bytes, pool word, method header, input char
// rsp      out  next pc, output char, status, top of stack
//
// a request steps through read, execute, an optional stack top refresh, then result
// swap adds a second stack write step; a call moves each argument after the first to locals
// with a read and a write step each, set by the single read port of the operand stack memory
// rst clears pc, stack pointer, frame depth, locals window and stop flag
// a result is held until taken; no request is taken before that
`default_nettype none
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH  = 1024,
  parameter int FRAME_DEPTH  = 64,
  parameter int LOCALS_DEPTH = 4096
) (
  input  wire        clk,
  input  wire        rst,
  smeu_req_if.sink   req,
  smeu_rsp_if.source rsp
);
  import smeu_pkg::*;

  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SP_W = SA_W + 1;
  localparam int FA_W = $clog2(FRAME_DEPTH);
  localparam int FD_W = FA_W + 1;
  localparam int LA_W = $clog2(LOCALS_DEPTH);
  localparam int LC_W = LA_W + 1;
  localparam int FR_W = 16 + SP_W + 2 * LC_W;

  localparam logic [SP_W-1:0]   SP_MAX = SP_W'(STACK_DEPTH);
  localparam logic [FD_W-1:0]   FD_MAX = FD_W'(FRAME_DEPTH);
  localparam logic [CALC_W-1:0] LD_MAX = CALC_W'(LOCALS_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_W2   = 4'd3;
  localparam logic [3:0] S_CRD  = 4'd4;
  localparam logic [3:0] S_CWR  = 4'd5;
  localparam logic [3:0] S_FIX  = 4'd6;
  localparam logic [3:0] S_FIX2 = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]      state;
  logic [15:0]     pc;
  logic [SP_W-1:0] sp;
  logic [FD_W-1:0] fd;
  logic [LC_W-1:0] lbase;
  logic [LC_W-1:0] lcount;
  logic            stopped;
  logic [31:0]     top;
  req_t            r;
  logic [2:0]      res_st;
  logic            res_ov;
  logic [7:0]      res_oc;
  logic [SA_W-1:0] w2a;
  logic [31:0]     w2d;
  logic [15:0]     ck;
  logic [15:0]     cn;
  logic [SP_W-1:0] csb;
  logic [LC_W-1:0] cnb;

  // memories
  logic [31:0]     stk [STACK_DEPTH];
  logic [31:0]     loc [LOCALS_DEPTH];
  logic [FR_W-1:0] frm [FRAME_DEPTH];
  logic [31:0]     srd;
  logic [31:0]     lrd;
  logic [FR_W-1:0] frd;

  logic            s_we;
  logic [SA_W-1:0] s_wa;
  logic [31:0]     s_wd;
  logic [SA_W-1:0] s_ra;
  logic            l_we;
  logic [LA_W-1:0] l_wa;
  logic [31:0]     l_wd;
  logic            f_we;

  // decode helpers
  logic [15:0]       u16;
  logic [15:0]       idx16;
  logic [CALC_W-1:0] idx_c;
  logic [CALC_W-1:0] sp_c;
  logic [CALC_W-1:0] nargs_c;
  logic [CALC_W-1:0] nb;
  logic [CALC_W-1:0] need;
  logic              in_frame;
  logic              can_grow;
  logic [LC_W-1:0]   grow_cnt;
  logic [31:0]       lv;
  logic [LA_W-1:0]   laddr;
  logic [15:0]       f_ret;
  logic [SP_W-1:0]   f_top;
  logic [LC_W-1:0]   f_base;
  logic [LC_W-1:0]   f_cnt;

  // execute results
  logic [2:0]      ex_st;
  logic            ex_bad;
  logic [2:0]      st_f;
  logic            ok;
  logic [15:0]     ex_np;
  logic            ex_ov;
  logic [7:0]      ex_oc;
  logic            ex_swe;
  logic [SA_W-1:0] ex_swa;
  logic [31:0]     ex_swd;
  logic [SP_W-1:0] ex_sp;
  logic [31:0]     ex_top;
  logic            ex_fix;
  logic            ex_lwe;
  logic [LA_W-1:0] ex_lwa;
  logic [31:0]     ex_lwd;
  logic [LC_W-1:0] ex_lcnt;
  logic [LC_W-1:0] ex_lbase;
  logic [FD_W-1:0] ex_fd;
  logic            ex_fwe;
  logic [FR_W-1:0] ex_fwd;
  logic            ex_w2;
  logic            ex_call;

  assign u16      = {r.operand_a, r.operand_b};
  assign idx16    = r.wide ? u16 : {8'h00, r.operand_a};
  assign idx_c    = CALC_W'(idx16);
  assign sp_c     = CALC_W'(sp);
  assign nargs_c  = CALC_W'(r.method_args);
  assign nb       = CALC_W'(lbase) + CALC_W'(lcount);
  assign need     = nb + nargs_c + CALC_W'(r.method_locals);
  assign in_frame = idx_c < CALC_W'(lcount);
  assign can_grow = in_frame || ((CALC_W'(lbase) + idx_c) < LD_MAX);
  assign grow_cnt = in_frame ? lcount : LC_W'(idx_c + CALC_W'(1));
  assign lv       = in_frame ? lrd : 32'd0;
  assign laddr    = LA_W'(CALC_W'(lbase) + idx_c);
  assign {f_ret, f_top, f_base, f_cnt} = frd;

  always_comb begin
    ex_st    = ST_RUN;
    ex_bad   = 1'b0;
    ex_np    = pc + 16'd1;
    ex_ov    = 1'b0;
    ex_oc    = 8'h00;
    ex_swe   = 1'b0;
    ex_swa   = SA_W'(sp);
    ex_swd   = 32'd0;
    ex_sp    = sp;
    ex_top   = top;
    ex_fix   = 1'b0;
    ex_lwe   = 1'b0;
    ex_lwa   = laddr;
    ex_lwd   = top;
    ex_lcnt  = lcount;
    ex_lbase = lbase;
    ex_fd    = fd;
    ex_fwe   = 1'b0;
    ex_fwd   = {pc + 16'd3, SP_W'(sp_c - nargs_c), lbase, lcount};
    ex_w2    = 1'b0;
    ex_call  = 1'b0;
    if (stopped) begin
      ex_st = ST_HALT;
    end else if (r.wide || r.action == OP_WIDE) begin
      ex_np = pc + 16'd2;
      if (r.wide && r.action == OP_PUSH_BYTE) begin
        if (sp >= SP_MAX) begin
          ex_bad = 1'b1;
        end else begin
          ex_swe = 1'b1;
          ex_swd = {{16{r.operand_a[7]}}, u16};
          ex_sp  = sp + SP_W'(1);
          ex_top = ex_swd;
          ex_np  = pc + 16'd4;
        end
      end else if (r.wide && r.action == OP_LOAD_LOCAL) begin
        if (sp >= SP_MAX) begin
          ex_bad = 1'b1;
        end else begin
          ex_swe = 1'b1;
          ex_swd = lv;
          ex_sp  = sp + SP_W'(1);
          ex_top = lv;
          ex_np  = pc + 16'd4;
        end
      end else if (r.wide && r.action == OP_STORE_LOCAL) begin
        if (sp == '0 || !can_grow) begin
          ex_bad = 1'b1;
        end else begin
          ex_lwe  = 1'b1;
          ex_lcnt = grow_cnt;
          ex_sp   = sp - SP_W'(1);
          ex_fix  = 1'b1;
          ex_np   = pc + 16'd4;
        end
      end
    end else begin
      case (r.action)
        OP_NOP: begin
        end
        OP_PUSH_BYTE, OP_PUSH_CONST, OP_LOAD_LOCAL, OP_IN: begin
          if (sp >= SP_MAX) begin
            ex_bad = 1'b1;
          end else begin
            ex_swe = 1'b1;
            ex_sp  = sp + SP_W'(1);
            case (r.action)
              OP_PUSH_BYTE: begin
                ex_swd = {{24{r.operand_a[7]}}, r.operand_a};
                ex_np  = pc + 16'd2;
              end
              OP_PUSH_CONST: begin
                ex_swd = r.pool_word;
                ex_np  = pc + 16'd3;
              end
              OP_LOAD_LOCAL: begin
                ex_swd = lv;
                ex_np  = pc + 16'd2;
              end
              default: ex_swd = r.in_valid ? {24'h0, r.in_char} : 32'd0;
            endcase
            ex_top = ex_swd;
          end
        end
        OP_STORE_LOCAL: begin
          if (sp == '0 || !can_grow) begin
            ex_bad = 1'b1;
          end else begin
            ex_lwe  = 1'b1;
            ex_lcnt = grow_cnt;
            ex_sp   = sp - SP_W'(1);
            ex_fix  = 1'b1;
            ex_np   = pc + 16'd2;
          end
        end
        OP_IINC: begin
          if (!can_grow) begin
            ex_bad = 1'b1;
          end else begin
            ex_lwe  = 1'b1;
            ex_lwd  = lv + {{24{r.operand_b[7]}}, r.operand_b};
            ex_lcnt = grow_cnt;
            ex_np   = pc + 16'd3;
          end
        end
        OP_POP: begin
          if (sp == '0) begin
            ex_bad = 1'b1;
          end else begin
            ex_sp  = sp - SP_W'(1);
            ex_fix = 1'b1;
          end
        end
        OP_DUP: begin
          if (sp == '0 || sp >= SP_MAX) begin
            ex_bad = 1'b1;
          end else begin
            ex_swe = 1'b1;
            ex_swd = top;
            ex_sp  = sp + SP_W'(1);
          end
        end
        OP_SWAP: begin
          if (sp < SP_W'(2)) begin
            ex_bad = 1'b1;
          end else begin
            ex_swe = 1'b1;
            ex_swa = SA_W'(sp - SP_W'(2));
            ex_swd = top;
            ex_w2  = 1'b1;
            ex_top = srd;
          end
        end
        OP_IADD, OP_ISUB, OP_IAND, OP_IOR: begin
          if (sp < SP_W'(2)) begin
            ex_bad = 1'b1;
          end else begin
            ex_swe = 1'b1;
            ex_swa = SA_W'(sp - SP_W'(2));
            case (r.action)
              OP_IADD: ex_swd = srd + top;
              OP_ISUB: ex_swd = srd - top;
              OP_IAND: ex_swd = srd & top;
              default: ex_swd = srd | top;
            endcase
            ex_sp  = sp - SP_W'(1);
            ex_top = ex_swd;
          end
        end
        OP_GOTO: ex_np = pc + u16;
        OP_IFEQ, OP_IFLT: begin
          if (sp == '0) begin
            ex_bad = 1'b1;
          end else begin
            ex_sp  = sp - SP_W'(1);
            ex_fix = 1'b1;
            if (r.action == OP_IFEQ ? (top == 32'd0) : top[31]) ex_np = pc + u16;
            else ex_np = pc + 16'd3;
          end
        end
        OP_IF_ICMPEQ: begin
          if (sp < SP_W'(2)) begin
            ex_bad = 1'b1;
          end else begin
            ex_sp  = sp - SP_W'(2);
            ex_fix = 1'b1;
            ex_np  = (top == srd) ? pc + u16 : pc + 16'd3;
          end
        end
        OP_OUT: begin
          if (sp == '0) begin
            ex_bad = 1'b1;
          end else begin
            ex_sp  = sp - SP_W'(1);
            ex_fix = 1'b1;
            ex_ov  = 1'b1;
            ex_oc  = top[7:0];
          end
        end
        OP_INVOKE: begin
          if (fd >= FD_MAX || nargs_c > sp_c || need > LD_MAX) begin
            ex_bad = 1'b1;
          end else begin
            ex_fwe   = 1'b1;
            ex_fd    = fd + FD_W'(1);
            ex_lbase = LC_W'(nb);
            ex_lcnt  = LC_W'(nargs_c + CALC_W'(r.method_locals));
            ex_np    = 16'(r.pool_word) + 16'd4;
            // local 0 of the new frame reads as zero
            ex_lwe   = (ex_lcnt != '0);
            ex_lwa   = LA_W'(nb);
            ex_lwd   = 32'd0;
            if (r.method_args != 16'd0) begin
              ex_sp  = SP_W'(sp_c - nargs_c + CALC_W'(1));
              ex_fix = 1'b1;
            end
            ex_call = (r.method_args > 16'd1);
          end
        end
        OP_RETURN: begin
          if (fd == '0 || sp == '0) begin
            ex_bad = 1'b1;
          end else if (sp < f_top || f_top >= SP_MAX) begin
            ex_bad = 1'b1;
          end else begin
            ex_swe   = 1'b1;
            ex_swa   = SA_W'(f_top);
            ex_swd   = top;
            ex_sp    = f_top + SP_W'(1);
            ex_lbase = f_base;
            ex_lcnt  = f_cnt;
            ex_np    = f_ret;
            ex_fd    = fd - FD_W'(1);
          end
        end
        OP_HALT: ex_st = ST_HALT;
        OP_ERR:  ex_st = ST_ERR;
        default: ex_st = ST_BADOP;
      endcase
    end
  end

  assign st_f = ex_bad ? ST_BOUND : ex_st;
  assign ok   = (st_f == ST_RUN);

  always_comb begin
    unique case (state)
      S_FIX:   s_ra = SA_W'(sp - SP_W'(1));
      S_CRD:   s_ra = SA_W'(CALC_W'(csb) + CALC_W'(ck));
      default: s_ra = SA_W'(sp - SP_W'(2));
    endcase
  end

  assign s_we = (state == S_EXEC && ok && ex_swe) || state == S_W2;
  assign s_wa = (state == S_W2) ? w2a : ex_swa;
  assign s_wd = (state == S_W2) ? w2d : ex_swd;
  assign l_we = (state == S_EXEC && ok && ex_lwe) || state == S_CWR;
  assign l_wa = (state == S_CWR) ? LA_W'(CALC_W'(cnb) + CALC_W'(ck)) : ex_lwa;
  assign l_wd = (state == S_CWR) ? srd : ex_lwd;
  assign f_we = state == S_EXEC && ok && ex_fwe;

  always_ff @(posedge clk) begin
    if (s_we) stk[s_wa] <= s_wd;
    srd <= stk[s_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) loc[l_wa] <= l_wd;
    lrd <= loc[laddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) frm[FA_W'(fd)] <= ex_fwd;
    frd <= frm[FA_W'(fd - FD_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= 16'd0;
      sp      <= '0;
      fd      <= '0;
      lbase   <= '0;
      lcount  <= '0;
      stopped <= 1'b0;
      top     <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r     <= req.data;
            state <= S_RD;
          end
        end
        S_RD: state <= S_EXEC;
        S_EXEC: begin
          res_st <= st_f;
          res_ov <= ok & ex_ov;
          res_oc <= ok ? ex_oc : 8'h00;
          w2a    <= SA_W'(sp - SP_W'(1));
          w2d    <= srd;
          ck     <= 16'd1;
          cn     <= r.method_args;
          csb    <= SP_W'(sp_c - nargs_c);
          cnb    <= LC_W'(nb);
          if (!ok) begin
            stopped <= 1'b1;
            state   <= S_OUT;
          end else begin
            pc     <= ex_np;
            sp     <= ex_sp;
            top    <= ex_top;
            fd     <= ex_fd;
            lbase  <= ex_lbase;
            lcount <= ex_lcnt;
            if (ex_w2) state <= S_W2;
            else if (ex_call) state <= S_CRD;
            else if (ex_fix && ex_sp != '0) state <= S_FIX;
            else state <= S_OUT;
          end
        end
        S_W2: state <= S_OUT;
        S_CRD: state <= S_CWR;
        S_CWR: begin
          ck <= ck + 16'd1;
          if (ck + 16'd1 == cn) state <= S_FIX;
          else state <= S_CRD;
        end
        S_FIX: state <= S_FIX2;
        S_FIX2: begin
          top   <= srd;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = (state == S_OUT);
  assign rsp.data.next_pc   = pc;
  assign rsp.data.out_valid = res_ov;
  assign rsp.data.out_char  = res_oc;
  assign rsp.data.status    = res_st;
  assign rsp.data.top_word  = (sp == '0) ? 32'd0 : top;

endmodule
`default_nettype wire
